// ----- hdl/prc_pkg.sv -----
// Shared types, codes and constants of the palette range cycler.
// The request/response payloads, the microcode word and the reset palette live here.
// No dependencies.
package prc_pkg;

   // Request operations
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_FIRST   = 2'd0;
   localparam logic [1:0] CSR_LAST    = 2'd1;
   localparam logic [1:0] CSR_REVERSE = 2'd2;
   localparam logic [1:0] CSR_PERIOD  = 2'd3;

   localparam logic [7:0] FIRST_RESET   = 8'd16;
   localparam logic [7:0] LAST_RESET    = 8'd25;
   localparam logic       REVERSE_RESET = 1'b0;
   localparam logic [7:0] PERIOD_RESET  = 8'd5;
   localparam logic [7:0] PERIOD_OFF    = 8'd255;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  entry_index;
      logic [23:0] colour_in;
      logic [7:0]  tag_in;
   } req_type;

   typedef struct packed {
      logic [23:0] colour_out;
      logic [7:0]  tag_out;
      logic        rotated;
   } rsp_type;

   // Microprogram step addresses. Tick, read, write and none are consecutive
   // so that dispatch adds the op code to the tick entry.
   typedef enum logic [3:0] {
      STEP_INIT,
      STEP_IDLE,
      STEP_TICK,
      STEP_READ,
      STEP_WRITE,
      STEP_NOP,
      STEP_RESP_ZERO,
      STEP_RESP_READ,
      STEP_ROT_READ0,
      STEP_ROT_READ1,
      STEP_ROT_LOOP,
      STEP_ROT_TAIL,
      STEP_RESP_ROT
   } step_type;

   typedef enum logic [1:0] {RD_NONE, RD_REQ, RD_ROT} rd_sel_type;
   typedef enum logic [2:0] {WR_NONE, WR_INIT, WR_REQ, WR_ROT_DATA, WR_ROT_HOLD} wr_sel_type;
   typedef enum logic [1:0] {PTR_HOLD, PTR_START, PTR_INC, PTR_STEP} ptr_op_type;
   typedef enum logic [1:0] {RSP_NONE, RSP_ZERO, RSP_READ, RSP_ROT} rsp_sel_type;
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_WP_LAST,
      COND_ACCEPT,
      COND_ROT_GO,
      COND_RSP_FREE,
      COND_WP_END
   } cond_type;

   // Datapath controls of one microcode step
   typedef struct packed {
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      ptr_op_type  wp_op;
      ptr_op_type  rp_op;
      logic        hold_load;
      logic        tick_eval;
      logic        req_ready;
      rsp_sel_type rsp_sel;
   } ctrl_type;

   typedef struct packed {
      ctrl_type ctrl;
      cond_type cond;
      logic     dispatch;
      step_type tgt_a;
      step_type tgt_b;
   } uword_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic       accept;
      logic [1:0] op;
      logic       wp_last;
      logic       wp_end;
      logic       rot_go;
      logic       rsp_free;
   } status_type;

   localparam logic [23:0] DEFAULT_PALETTE [0:255] = '{
   24'h000000, 24'hAFAFAF, 24'hFFFFFF, 24'h3B67A2, 24'hAA907C, 24'h959595, 24'h7B7B7B, 24'hFFA997,
   24'h37A91D, 24'h7CA9FF, 24'hBF8112, 24'hEBBF66, 24'h78C178, 24'h3D9318, 24'hB33418, 24'hD9311C,
   24'h000000, 24'h00001C, 24'h000039, 24'h000055, 24'h000071, 24'h00018E, 24'h0001AA, 24'h0001C6,
   24'h0001E3, 24'h0001FF, 24'hCECECE, 24'h00FF00, 24'hB2FF00, 24'hFFE700, 24'hFF9600, 24'hFF1100,
   24'h491200, 24'h491355, 24'h4914AA, 24'h4916FF, 24'h5B1700, 24'h5B1855, 24'h5B19AA, 24'h5B1AFF,
   24'h6D1B00, 24'h6D1C55, 24'h00E300, 24'h85FF54, 24'hC4FF00, 24'hFFD900, 24'hFFA41F, 24'hE05400,
   24'hFF0000, 24'h922655, 24'h9227AA, 24'h9228FF, 24'hA42900, 24'hA42A55, 24'hA42BAA, 24'hA42CFF,
   24'hB62D00, 24'hB62F55, 24'hB630AA, 24'hB631FF, 24'hC93200, 24'hC93355, 24'hC934AA, 24'hC935FF,
   24'hDB3700, 24'hDB3855, 24'hDB39AA, 24'hDB3AFF, 24'hED3B00, 24'hED3C55, 24'hED3DAA, 24'hED3FFF,
   24'hFF4000, 24'hFF4155, 24'hFF42AA, 24'hFF43FF, 24'h004400, 24'h004555, 24'h0046AA, 24'h0048FF,
   24'hFFFF00, 24'h12FF55, 24'h12EE55, 24'h12B6FF, 24'h001FFF, 24'h9D0EC7, 24'hF10000, 24'hFF7700,
   24'h375200, 24'h375355, 24'h3754AA, 24'h3755FF, 24'h495600, 24'h495855, 24'h4959AA, 24'h495AFF,
   24'h5B5B00, 24'h5B5C55, 24'h5B5DAA, 24'h5B5EFF, 24'h6D6000, 24'h6D6155, 24'h6D62AA, 24'h6D63FF,
   24'h6D6400, 24'h806555, 24'h8066AA, 24'h8067FF, 24'h926900, 24'h926A55, 24'h926BAA, 24'h926CFF,
   24'hA46D00, 24'hA46E55, 24'hA46FAA, 24'hA471FF, 24'hB67200, 24'hB67355, 24'hB674AA, 24'hB675FF,
   24'hC97600, 24'hC97755, 24'hC979AA, 24'hC97AFF, 24'hDB7B00, 24'hDB7C55, 24'hDB7DAA, 24'hDB7EFF,
   24'hED7F00, 24'hED8055, 24'hED82AA, 24'hED83FF, 24'hFF8400, 24'hFF8555, 24'hFF86AA, 24'hFF87FF,
   24'h008800, 24'h008A55, 24'h008BAA, 24'h008CFF, 24'h128D00, 24'h128E55, 24'h128FAA, 24'h1290FF,
   24'h249200, 24'h249355, 24'h2494AA, 24'h2495FF, 24'h379600, 24'h379755, 24'h3798AA, 24'h3799FF,
   24'h499B00, 24'h499C55, 24'h499DAA, 24'h499EFF, 24'h5B9F00, 24'h5BA055, 24'h5BA1AA, 24'h5BA3FF,
   24'hA4B5D5, 24'hA0B0F8, 24'h94A3E6, 24'h7C89C1, 24'h6281C0, 24'h1C62A1, 24'h4254EA, 24'h62A1BD,
   24'h7093C0, 24'h4977A1, 24'h003FAA, 24'h1554FF, 24'h1C50B9, 24'h00B3FF, 24'h0088AA, 24'h00B5FF,
   24'h0E62FF, 24'h5EB7E3, 24'hBDC0B9, 24'h85B9FF, 24'h006CAF, 24'h1F81B9, 24'h3F5BAA, 24'hC9BEFF,
   24'h5BAFCB, 24'hDBC055, 24'hDBC1AA, 24'hBDC0C0, 24'hEDC400, 24'hEDC555, 24'hEDC6AA, 24'hEDC7FF,
   24'hFFC800, 24'hFFC955, 24'hFFCAAA, 24'hFFCCFF, 24'h00CD00, 24'h00CE55, 24'h00CFAA, 24'h00D0FF,
   24'h12D100, 24'h12D255, 24'h12D3AA, 24'h12D5FF, 24'h24D600, 24'h24D755, 24'h24D8AA, 24'h24D9FF,
   24'h100020, 24'h1B0029, 24'h250032, 24'h30003A, 24'h3B0043, 24'h45004C, 24'h500055, 24'h49E2FF,
   24'h5BE300, 24'h5BE555, 24'h5BE6AA, 24'h5BE7FF, 24'h6DE800, 24'h6DE955, 24'h6DEAAA, 24'h6DEBFF,
   24'h6DEC00, 24'h80EE55, 24'h80EFAA, 24'h80F0FF, 24'h93CEA2, 24'h92F255, 24'h92F3AA, 24'h92F4FF,
   24'hA4F600, 24'hA4F755, 24'hA4F8AA, 24'hA4F9FF, 24'hB6FA00, 24'hB6FB55, 24'hB6FCAA, 24'hB6FEFF,
   24'hC9FF00, 24'hC9FF55, 24'hC9FFAA, 24'hC9FFFF, 24'hDBFF00, 24'hDBFF55, 24'hDBFFAA, 24'hDBFFFF,
   24'hEDFF00, 24'hEDFF55, 24'hEDFFAA, 24'hEDFFFF, 24'hFFFF00, 24'hFFFF55, 24'hFFFFAA, 24'hFFFFFF
   };

   function automatic logic [23:0] default_colour(input logic [7:0] idx);
      return DEFAULT_PALETTE[idx];
   endfunction

endpackage

// ----- hdl/prc_sequencer.sv -----
// Microcode sequencer of the palette range cycler: step counter, control store
// and conditional jump logic. Depends on prc_pkg.
module prc_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  prc_pkg::status_type status,
   output prc_pkg::ctrl_type   ctrl
);

   prc_pkg::step_type  step_ff;
   prc_pkg::step_type  step_in;
   prc_pkg::uword_type word;
   logic               cond_true;

   // Control store
   always_comb begin
      word                = '0;
      word.ctrl.rd_sel    = prc_pkg::RD_NONE;
      word.ctrl.wr_sel    = prc_pkg::WR_NONE;
      word.ctrl.wp_op     = prc_pkg::PTR_HOLD;
      word.ctrl.rp_op     = prc_pkg::PTR_HOLD;
      word.ctrl.rsp_sel   = prc_pkg::RSP_NONE;
      word.cond           = prc_pkg::COND_ALWAYS;
      word.tgt_a          = prc_pkg::STEP_IDLE;
      word.tgt_b          = prc_pkg::STEP_IDLE;
      case (step_ff)
         prc_pkg::STEP_INIT: begin
            word.ctrl.wr_sel = prc_pkg::WR_INIT;
            word.ctrl.wp_op  = prc_pkg::PTR_INC;
            word.cond        = prc_pkg::COND_WP_LAST;
            word.tgt_a       = prc_pkg::STEP_IDLE;
            word.tgt_b       = prc_pkg::STEP_INIT;
         end
         prc_pkg::STEP_IDLE: begin
            word.ctrl.req_ready = 1'b1;
            word.cond           = prc_pkg::COND_ACCEPT;
            word.dispatch       = 1'b1;
            word.tgt_a          = prc_pkg::STEP_TICK;
            word.tgt_b          = prc_pkg::STEP_IDLE;
         end
         prc_pkg::STEP_TICK: begin
            word.ctrl.tick_eval = 1'b1;
            word.ctrl.wp_op     = prc_pkg::PTR_START;
            word.ctrl.rp_op     = prc_pkg::PTR_START;
            word.cond           = prc_pkg::COND_ROT_GO;
            word.tgt_a          = prc_pkg::STEP_ROT_READ0;
            word.tgt_b          = prc_pkg::STEP_RESP_ZERO;
         end
         prc_pkg::STEP_READ: begin
            word.ctrl.rd_sel = prc_pkg::RD_REQ;
            word.tgt_a       = prc_pkg::STEP_RESP_READ;
         end
         prc_pkg::STEP_WRITE: begin
            word.ctrl.wr_sel = prc_pkg::WR_REQ;
            word.tgt_a       = prc_pkg::STEP_RESP_ZERO;
         end
         prc_pkg::STEP_NOP: begin
            word.tgt_a = prc_pkg::STEP_RESP_ZERO;
         end
         prc_pkg::STEP_RESP_ZERO: begin
            word.ctrl.rsp_sel = prc_pkg::RSP_ZERO;
            word.cond         = prc_pkg::COND_RSP_FREE;
            word.tgt_b        = prc_pkg::STEP_RESP_ZERO;
         end
         prc_pkg::STEP_RESP_READ: begin
            word.ctrl.rsp_sel = prc_pkg::RSP_READ;
            word.cond         = prc_pkg::COND_RSP_FREE;
            word.tgt_b        = prc_pkg::STEP_RESP_READ;
         end
         prc_pkg::STEP_ROT_READ0: begin
            word.ctrl.rd_sel = prc_pkg::RD_ROT;
            word.ctrl.rp_op  = prc_pkg::PTR_STEP;
            word.tgt_a       = prc_pkg::STEP_ROT_READ1;
         end
         prc_pkg::STEP_ROT_READ1: begin
            word.ctrl.rd_sel    = prc_pkg::RD_ROT;
            word.ctrl.rp_op     = prc_pkg::PTR_STEP;
            word.ctrl.hold_load = 1'b1;
            word.tgt_a          = prc_pkg::STEP_ROT_LOOP;
         end
         prc_pkg::STEP_ROT_LOOP: begin
            word.ctrl.rd_sel = prc_pkg::RD_ROT;
            word.ctrl.rp_op  = prc_pkg::PTR_STEP;
            word.ctrl.wr_sel = prc_pkg::WR_ROT_DATA;
            word.ctrl.wp_op  = prc_pkg::PTR_STEP;
            word.cond        = prc_pkg::COND_WP_END;
            word.tgt_a       = prc_pkg::STEP_ROT_TAIL;
            word.tgt_b       = prc_pkg::STEP_ROT_LOOP;
         end
         prc_pkg::STEP_ROT_TAIL: begin
            word.ctrl.wr_sel = prc_pkg::WR_ROT_HOLD;
            word.tgt_a       = prc_pkg::STEP_RESP_ROT;
         end
         prc_pkg::STEP_RESP_ROT: begin
            word.ctrl.rsp_sel = prc_pkg::RSP_ROT;
            word.cond         = prc_pkg::COND_RSP_FREE;
            word.tgt_b        = prc_pkg::STEP_RESP_ROT;
         end
         default: begin
            word.tgt_a = prc_pkg::STEP_IDLE;
         end
      endcase
   end

   always_comb begin
      case (word.cond)
         prc_pkg::COND_ALWAYS:   cond_true = 1'b1;
         prc_pkg::COND_WP_LAST:  cond_true = status.wp_last;
         prc_pkg::COND_ACCEPT:   cond_true = status.accept;
         prc_pkg::COND_ROT_GO:   cond_true = status.rot_go;
         prc_pkg::COND_RSP_FREE: cond_true = status.rsp_free;
         prc_pkg::COND_WP_END:   cond_true = status.wp_end;
         default:                cond_true = 1'b1;
      endcase
      if (!cond_true) begin
         step_in = word.tgt_b;
      end else if (word.dispatch) begin
         step_in = prc_pkg::step_type'(4'(word.tgt_a) + {2'b00, status.op});
      end else begin
         step_in = word.tgt_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= prc_pkg::STEP_INIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl = word.ctrl;

endmodule

// ----- hdl/prc_datapath.sv -----
// Datapath of the palette range cycler: colour/tag memory, pointers, tick divider,
// configuration registers and response register. Depends on prc_pkg.
module prc_datapath #(
   parameter int ENTRIES     = 256,
   parameter int COLOUR_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  prc_pkg::ctrl_type   ctrl,
   output prc_pkg::status_type status,
   input  logic                req_valid,
   input  prc_pkg::req_type    req_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output prc_pkg::rsp_type    rsp_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int WW = COLOUR_BITS + 8;

   // Configuration
   logic [7:0] first_ff, last_ff, period_ff;
   logic       reverse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= prc_pkg::FIRST_RESET;
         last_ff    <= prc_pkg::LAST_RESET;
         reverse_ff <= prc_pkg::REVERSE_RESET;
         period_ff  <= prc_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            prc_pkg::CSR_FIRST:   first_ff   <= csr_wdata;
            prc_pkg::CSR_LAST:    last_ff    <= csr_wdata;
            prc_pkg::CSR_REVERSE: reverse_ff <= csr_wdata[0];
            prc_pkg::CSR_PERIOD:  period_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Range ends, saturated to the table
   logic [8:0]    first_wide, last_wide, lo_wide, hi_wide;
   logic [AW-1:0] lo, hi, rot_start, rot_end;

   always_comb begin
      first_wide = {1'b0, first_ff};
      last_wide  = {1'b0, last_ff};
      lo_wide    = (first_wide >= 9'(ENTRIES)) ? 9'(ENTRIES - 1) : first_wide;
      hi_wide    = (last_wide >= 9'(ENTRIES)) ? 9'(ENTRIES - 1) : last_wide;
      lo         = lo_wide[AW-1:0];
      hi         = hi_wide[AW-1:0];
      rot_start  = reverse_ff ? hi : lo;
      rot_end    = reverse_ff ? lo : hi;
   end

   // Request capture
   prc_pkg::req_type req_ff;
   logic             accept;
   logic [8:0]       req_idx_wide;
   logic             req_hit;
   logic [AW-1:0]    req_addr;

   assign accept       = req_valid && ctrl.req_ready;
   assign req_idx_wide = {1'b0, req_ff.entry_index};
   assign req_hit      = req_idx_wide < 9'(ENTRIES);
   assign req_addr     = req_ff.entry_index[AW-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Tick divider
   logic [7:0] div_ff, div_in;
   logic [8:0] div_next;
   logic       cycling, tick_wrap, rot_go;

   always_comb begin
      div_next  = {1'b0, div_ff} + 9'd1;
      cycling   = period_ff != prc_pkg::PERIOD_OFF;
      tick_wrap = cycling && (div_next > {1'b0, period_ff});
      rot_go    = tick_wrap && (lo < hi);
      div_in    = div_ff;
      if (ctrl.tick_eval && cycling) begin
         div_in = tick_wrap ? 8'd0 : div_next[7:0];
      end
   end

   // Write and read pointers
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in, wp_fwd, rp_fwd;
   logic [AW:0]   rp_wide;

   always_comb begin
      wp_fwd = reverse_ff ? (wp_ff - AW'(1)) : (wp_ff + AW'(1));
      rp_fwd = reverse_ff ? (rp_ff - AW'(1)) : (rp_ff + AW'(1));
      case (ctrl.wp_op)
         prc_pkg::PTR_START: wp_in = rot_start;
         prc_pkg::PTR_INC:   wp_in = wp_ff + AW'(1);
         prc_pkg::PTR_STEP:  wp_in = wp_fwd;
         default:            wp_in = wp_ff;
      endcase
      case (ctrl.rp_op)
         prc_pkg::PTR_START: rp_in = rot_start;
         prc_pkg::PTR_STEP:  rp_in = rp_fwd;
         default:            rp_in = rp_ff;
      endcase
      rp_wide = {1'b0, rp_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= 8'd0;
         wp_ff  <= '0;
      end else begin
         div_ff <= div_in;
         wp_ff  <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff <= rp_in;
   end

   // Reset contents for the clearing pass
   logic [AW+7:0]          wp_wide;
   logic [7:0]             init_tag;
   logic [COLOUR_BITS+23:0] init_wide;
   logic [COLOUR_BITS-1:0] init_colour;
   logic [COLOUR_BITS+23:0] req_colour_wide;
   logic [COLOUR_BITS-1:0] req_colour;

   always_comb begin
      wp_wide         = {8'd0, wp_ff};
      init_tag        = wp_wide[7:0];
      init_wide       = {{COLOUR_BITS{1'b0}}, prc_pkg::default_colour(init_tag)};
      init_colour     = init_wide[COLOUR_BITS-1:0];
      req_colour_wide = {{COLOUR_BITS{1'b0}}, req_ff.colour_in};
      req_colour      = req_colour_wide[COLOUR_BITS-1:0];
   end

   // Table memory: colour in the upper bits, tag in the low byte
   logic [WW-1:0] table_mem [ENTRIES];
   logic [WW-1:0] rd_q_ff, hold_ff, wr_word;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_en, rd_en;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wp_ff;
      wr_word = rd_q_ff;
      case (ctrl.wr_sel)
         prc_pkg::WR_INIT: begin
            wr_en   = 1'b1;
            wr_word = {init_colour, init_tag};
         end
         prc_pkg::WR_REQ: begin
            wr_en   = req_hit;
            wr_addr = req_addr;
            wr_word = {req_colour, req_ff.tag_in};
         end
         prc_pkg::WR_ROT_DATA: begin
            wr_en = 1'b1;
         end
         prc_pkg::WR_ROT_HOLD: begin
            wr_en   = 1'b1;
            wr_word = hold_ff;
         end
         default: ;
      endcase
      rd_en   = 1'b0;
      rd_addr = rp_ff;
      case (ctrl.rd_sel)
         prc_pkg::RD_REQ: begin
            rd_en   = req_hit;
            rd_addr = req_addr;
         end
         prc_pkg::RD_ROT: begin
            rd_en = rp_wide < (AW + 1)'(ENTRIES);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_q_ff <= table_mem[rd_addr];
      end
      if (ctrl.hold_load) begin
         hold_ff <= rd_q_ff;
      end
   end

   // Response register
   prc_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in, rsp_free, rsp_load;
   logic [COLOUR_BITS+23:0] rd_colour_wide;

   always_comb begin
      rsp_free       = !rsp_valid_ff || rsp_ready;
      rsp_load       = (ctrl.rsp_sel != prc_pkg::RSP_NONE) && rsp_free;
      rsp_valid_in   = rsp_load || (rsp_valid_ff && !rsp_ready);
      rd_colour_wide = {24'd0, rd_q_ff[WW-1:8]};
      rsp_in         = '0;
      case (ctrl.rsp_sel)
         prc_pkg::RSP_READ: begin
            if (req_hit) begin
               rsp_in.colour_out = rd_colour_wide[23:0];
               rsp_in.tag_out    = rd_q_ff[7:0];
            end
         end
         prc_pkg::RSP_ROT: rsp_in.rotated = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.accept   = accept;
      status.op       = req_data.op;
      status.wp_last  = wp_ff == AW'(ENTRIES - 1);
      status.wp_end   = wp_fwd == rot_end;
      status.rot_go   = rot_go;
      status.rsp_free = rsp_free;
   end

endmodule

// ----- hdl/palette_range_cycler_top.sv -----
// A rotating tick holds the first entry of the range, copies the rest one table entry per
// cycle through the single-write, single-read table memory and writes the held entry at
// the far end. One request is in work at a time.
// Reset: synchronous; then a clearing pass loads the default palette and identity tags,
// during which no request is taken (configuration writes are taken).
module palette_range_cycler_top #(
   parameter int ENTRIES     = 256,
   parameter int COLOUR_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  prc_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prc_pkg::rsp_type rsp_data,
   // configuration writes
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);

   // Control word of the current microcode step and the flags it branches on
   prc_pkg::ctrl_type   ctrl;
   prc_pkg::status_type status;

   // Sequencer: step counter walks the control store. It holds in the clearing
   // loop after reset, waits for a request in idle, dispatches on the op code,
   // and on a rotating tick runs the copy loop until the write pointer hits the
   // far end of the range.
   prc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Datapath: table memory with a registered read, pointers that advance one
   // entry per cycle, the tick divider and the response register. The response
   // register lets the next request enter while a finished response is held.
   prc_datapath #(
      .ENTRIES     (ENTRIES),
      .COLOUR_BITS (COLOUR_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_valid (req_valid),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Ready only in the idle step of the microprogram
   assign req_ready = ctrl.req_ready;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for palette_range_cycler_top: predicts every response from its own palette model.
// Depends on prc_pkg (payload types, op and register codes, reset palette) and the top level.
module tb_top;

   // Longest quiet stretch allowed: clearing pass, a full-range rotation and the long
   // receiver hold-off all fit in it many times over.
   localparam int WATCHDOG_LIMIT = 4000;
   // Cycles to keep watching the response port once nothing is outstanding.
   localparam int SETTLE_CYCLES  = 300;
   // Receiver hold-off used to fill the block and stall its request port.
   localparam int HOLD_OFF_LONG  = 300;

   typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} stall_mode_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   prc_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   prc_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [7:0]       csr_wdata;

   // Palette model: both tables, the tick divider and the register copies
   logic [23:0] colour_mem [0:255];
   logic [7:0]  tag_mem    [0:255];
   logic [7:0]  divider;
   logic [7:0]  cfg_first;
   logic [7:0]  cfg_last;
   logic        cfg_reverse;
   logic [7:0]  cfg_period;

   prc_pkg::rsp_type expected_rsp [$];
   int      mismatch_count = 0;
   int      burst_left = 0;
   bit      gaps_enabled = 1'b1;
   int      hold_off_cycles = 0;

   palette_range_cycler_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Palette model
   // ---------------------------------------------------------------------------

   // Load the reset palette, identity tags and reset register values.
   task automatic reset_palette_model();
      int k;
      for (k = 0; k < 256; k++) begin
         colour_mem[k] = prc_pkg::DEFAULT_PALETTE[k];
         tag_mem[k]    = 8'(k);
      end
      divider     = '0;
      cfg_first   = prc_pkg::FIRST_RESET;
      cfg_last    = prc_pkg::LAST_RESET;
      cfg_reverse = prc_pkg::REVERSE_RESET;
      cfg_period  = prc_pkg::PERIOD_RESET;
   endtask

   // Apply one accepted request to the model and return the response it must cause.
   task automatic apply_request(input prc_pkg::req_type r, output prc_pkg::rsp_type result);
      logic [23:0] carry_colour;
      logic [7:0]  carry_tag;
      int k;
      result = '0;
      case (r.op)
         prc_pkg::OP_TICK: begin
            if (cfg_period != prc_pkg::PERIOD_OFF) begin
               if ({1'b0, divider} + 9'd1 > {1'b0, cfg_period}) begin
                  divider = '0;
                  // an empty range clears the divider but moves nothing
                  if (cfg_first < cfg_last) begin
                     if (!cfg_reverse) begin
                        carry_colour = colour_mem[cfg_first];
                        carry_tag    = tag_mem[cfg_first];
                        for (k = cfg_first; k < cfg_last; k++) begin
                           colour_mem[k] = colour_mem[k + 1];
                           tag_mem[k]    = tag_mem[k + 1];
                        end
                        colour_mem[cfg_last] = carry_colour;
                        tag_mem[cfg_last]    = carry_tag;
                     end else begin
                        carry_colour = colour_mem[cfg_last];
                        carry_tag    = tag_mem[cfg_last];
                        for (k = cfg_last; k > cfg_first; k--) begin
                           colour_mem[k] = colour_mem[k - 1];
                           tag_mem[k]    = tag_mem[k - 1];
                        end
                        colour_mem[cfg_first] = carry_colour;
                        tag_mem[cfg_first]    = carry_tag;
                     end
                     result.rotated = 1'b1;
                  end
               end else begin
                  divider = divider + 8'd1;
               end
            end
         end
         prc_pkg::OP_READ: begin
            result.colour_out = colour_mem[r.entry_index];
            result.tag_out    = tag_mem[r.entry_index];
         end
         prc_pkg::OP_WRITE: begin
            colour_mem[r.entry_index] = r.colour_in;
            tag_mem[r.entry_index]    = r.tag_in;
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------------------

   function automatic prc_pkg::req_type make_request(input logic [1:0] op,
                                                     input logic [7:0] idx,
                                                     input logic [23:0] colour,
                                                     input logic [7:0] tag);
      prc_pkg::req_type r;
      r.op          = op;
      r.entry_index = idx;
      r.colour_in   = colour;
      r.tag_in      = tag;
      return r;
   endfunction

   // Offer one request, in bursts with random gaps; predict its response once accepted.
   task automatic send_request(input prc_pkg::req_type item);
      prc_pkg::rsp_type want;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (!gaps_enabled || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(item, want);
      expected_rsp.push_back(want);
   endtask

   // Drop valid after the last request of a phase.
   task automatic end_phase();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Hold until every predicted response has come back.
   task automatic wait_drained();
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Write one register; the block is idle whenever this is called.
   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         prc_pkg::CSR_FIRST:   cfg_first   = value;
         prc_pkg::CSR_LAST:    cfg_last    = value;
         prc_pkg::CSR_REVERSE: cfg_reverse = value[0];
         prc_pkg::CSR_PERIOD:  cfg_period  = value;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_cycling(input logic [7:0] first, input logic [7:0] last,
                              input logic reverse, input logic [7:0] period);
      write_csr(prc_pkg::CSR_FIRST, first);
      write_csr(prc_pkg::CSR_LAST, last);
      // upper bits of the reverse write are don't-care; toggle them anyway
      write_csr(prc_pkg::CSR_REVERSE, {7'($urandom_range(0, 127)), reverse});
      write_csr(prc_pkg::CSR_PERIOD, period);
   endtask

   // Random request: mostly ticks, reads and writes, with addresses biased into the
   // cycled range so that rotations show up in the read data.
   function automatic prc_pkg::req_type random_request();
      prc_pkg::req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.op = prc_pkg::OP_TICK;
      else if (pick < 70) r.op = prc_pkg::OP_READ;
      else if (pick < 92) r.op = prc_pkg::OP_WRITE;
      else                r.op = prc_pkg::OP_NONE;
      if (cfg_first <= cfg_last && $urandom_range(0, 9) < 6)
         r.entry_index = 8'($urandom_range(cfg_first, cfg_last));
      else
         r.entry_index = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 15);
      if (pick == 0)      r.colour_in = '0;
      else if (pick == 1) r.colour_in = '1;
      else                r.colour_in = 24'($urandom());
      r.tag_in = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // Pick a cycling setup: mostly short ranges and small periods, now and then the
   // full table, an empty range, cycling off or a long period.
   task automatic pick_random_config();
      int lo;
      int shape;
      int pick;
      logic [7:0] first;
      logic [7:0] last;
      logic [7:0] period;
      lo    = $urandom_range(0, 255);
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         first = 8'd0;
         last  = 8'd255;
      end else if (shape == 1) begin
         first = 8'(lo);
         last  = 8'($urandom_range(0, lo));
      end else begin
         first = 8'(lo);
         last  = 8'((lo + $urandom_range(1, 15) > 255) ? 255 : lo + $urandom_range(1, 15));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7)       period = 8'($urandom_range(0, 3));
      else if (pick == 7) period = prc_pkg::PERIOD_OFF;
      else                period = 8'($urandom_range(4, 254));
      set_cycling(first, last, 1'($urandom_range(0, 1)), period);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Run on the reset setup: table extremes, every op and the first rotation.
   task automatic test_directed();
      int k;
      send_request(make_request(prc_pkg::OP_READ, 8'd0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd255, '0, '0));
      send_request(make_request(prc_pkg::OP_WRITE, 8'd0, 24'hFFFFFF, 8'hFF));
      send_request(make_request(prc_pkg::OP_WRITE, 8'd255, 24'h000000, 8'h00));
      send_request(make_request(prc_pkg::OP_READ, 8'd0, '1, '1));
      send_request(make_request(prc_pkg::OP_READ, 8'd255, '1, '1));
      // unused op must change nothing and answer all zero
      send_request(make_request(prc_pkg::OP_NONE, 8'hFF, '1, '1));
      send_request(make_request(prc_pkg::OP_NONE, 8'h00, '0, '0));
      // reset period 5: the sixth tick rotates 16..25 down
      for (k = 0; k < 6; k++)
         send_request(make_request(prc_pkg::OP_TICK, 8'(k * 51), '1, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd16, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd25, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd26, '0, '0));
      end_phase();
      wait_drained();
   endtask

   // Empty and single-entry ranges clear the divider without moving anything;
   // a two-entry range at the top of the table swaps.
   task automatic test_empty_ranges();
      int k;
      set_cycling(8'd200, 8'd100, 1'b0, 8'd0);
      for (k = 0; k < 3; k++) send_request(make_request(prc_pkg::OP_TICK, '0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd100, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd200, '0, '0));
      end_phase();
      wait_drained();
      set_cycling(8'd77, 8'd77, 1'b1, 8'd0);
      for (k = 0; k < 2; k++) send_request(make_request(prc_pkg::OP_TICK, '0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd77, '0, '0));
      end_phase();
      wait_drained();
      set_cycling(8'd254, 8'd255, 1'b1, 8'd0);
      for (k = 0; k < 2; k++) begin
         send_request(make_request(prc_pkg::OP_TICK, '0, '0, '0));
         send_request(make_request(prc_pkg::OP_READ, 8'd254, '0, '0));
         send_request(make_request(prc_pkg::OP_READ, 8'd255, '0, '0));
      end
      end_phase();
      wait_drained();
   endtask

   // Rotate the whole table both ways.
   task automatic test_full_range();
      int k;
      set_cycling(8'd0, 8'd255, 1'b1, 8'd0);
      for (k = 0; k < 3; k++) send_request(make_request(prc_pkg::OP_TICK, '0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd128, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd255, '0, '0));
      end_phase();
      wait_drained();
      write_csr(prc_pkg::CSR_REVERSE, 8'hFE);
      for (k = 0; k < 2; k++) send_request(make_request(prc_pkg::OP_TICK, '0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd255, '0, '0));
      end_phase();
      wait_drained();
   endtask

   // Cycling off holds the divider; a smaller period below the held count rotates on the
   // next tick; the largest enabled period rotates on tick 255.
   task automatic test_period_extremes();
      int k;
      set_cycling(8'd10, 8'd20, 1'b0, 8'd3);
      for (k = 0; k < 2; k++) send_request(make_request(prc_pkg::OP_TICK, '0, '0, '0));
      end_phase();
      wait_drained();
      write_csr(prc_pkg::CSR_PERIOD, prc_pkg::PERIOD_OFF);
      for (k = 0; k < 4; k++) send_request(make_request(prc_pkg::OP_TICK, '0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd10, '0, '0));
      end_phase();
      wait_drained();
      write_csr(prc_pkg::CSR_PERIOD, 8'd0);
      send_request(make_request(prc_pkg::OP_TICK, '0, '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd10, '0, '0));
      end_phase();
      wait_drained();
      write_csr(prc_pkg::CSR_PERIOD, 8'd254);
      for (k = 0; k < 256; k++)
         send_request(make_request(prc_pkg::OP_TICK, 8'(k), '0, '0));
      send_request(make_request(prc_pkg::OP_READ, 8'd20, '0, '0));
      end_phase();
      wait_drained();
   endtask

   // Stall the response port for a long stretch while requests keep coming back to back,
   // so the block fills up and drops req_ready.
   task automatic test_backpressure();
      int k;
      set_cycling(8'd40, 8'd47, 1'b1, 8'd1);
      @(posedge clock);
      hold_off_cycles = HOLD_OFF_LONG;
      gaps_enabled = 1'b0;
      for (k = 0; k < 24; k++) send_request(random_request());
      end_phase();
      gaps_enabled = 1'b1;
      wait_drained();
   endtask

   // Random phases, each on a fresh cycling setup.
   task automatic test_random(input int phases, input int per_phase);
      int p;
      int k;
      for (p = 0; p < phases; p++) begin
         pick_random_config();
         for (k = 0; k < per_phase; k++) send_request(random_request());
         end_phase();
         wait_drained();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: stall on a pattern drawn at random and redrawn when its run ends; honor the
   // long hold-off when a test asks for one.
   // ---------------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int mode_left;
      int beat;
      mode      = READY_ALWAYS;
      mode_left = 0;
      beat      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         beat++;
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               READY_ALWAYS:   rsp_ready <= 1'b1;
               READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               READY_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
               READY_PERIODIC: rsp_ready <= (beat % 5) < 2;
               default:        rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Checker: compare every accepted response with the oldest prediction.
   // ---------------------------------------------------------------------------
   initial begin : response_checker
      prc_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with nothing outstanding: %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.colour_out !== want.colour_out) begin
                  $display("%0t: colour_out expected %06h actual %06h", $time,
                           want.colour_out, rsp_data.colour_out);
                  mismatch_count++;
               end
               if (rsp_data.tag_out !== want.tag_out) begin
                  $display("%0t: tag_out expected %02h actual %02h", $time,
                           want.tag_out, rsp_data.tag_out);
                  mismatch_count++;
               end
               if (rsp_data.rotated !== want.rotated) begin
                  $display("%0t: rotated expected %0b actual %0b", $time,
                           want.rotated, rsp_data.rotated);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves for too long.
   // ---------------------------------------------------------------------------
   initial begin : stall_watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: nothing accepted for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : main_sequence
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = prc_pkg::CSR_FIRST;
      csr_wdata = '0;
      reset_palette_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_empty_ranges();
      test_full_range();
      test_period_extremes();
      test_backpressure();
      test_random(10, 90);

      // Drain, then keep watching for stray responses.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
